[rtl/weighted_kernel_scatter_accumulate_unit_assert.svh]
// Assertion macros for the weighted kernel scatter accumulate unit
`ifndef WEIGHTED_KERNEL_SCATTER_ACCUMULATE_UNIT_ASSERT_SVH
`define WEIGHTED_KERNEL_SCATTER_ACCUMULATE_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define WKSA_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define WKSA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/wksa_pkg.sv]
// Shared constants, types and arithmetic helpers of the scatter accumulate unit
package wksa_pkg;

	localparam int MAX_SIZE    = 64;
	localparam int MAX_KERNELS = 8;
	localparam int IDX_W       = $clog2(MAX_SIZE);
	localparam int KER_W       = $clog2(MAX_KERNELS);
	localparam int SQ_AW       = 2 * IDX_W;
	localparam int KS_AW       = KER_W + SQ_AW;

	typedef enum logic [2:0] {
		OP_KERNEL  = 3'd0,
		OP_KWEIGHT = 3'd1,
		OP_PWEIGHT = 3'd2,
		OP_DWEIGHT = 3'd3,
		OP_COMPUTE = 3'd4,
		OP_READ    = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		CFG_ACTIVE_SIZE = 2'd0,
		CFG_KERNELS     = 2'd1,
		CFG_START_ROW   = 2'd2,
		CFG_END_ROW     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [6:0] active_size;
		logic [3:0] kernels_in_use;
		logic [6:0] start_row;
		logic [6:0] end_row;
	} cfg_t;

	// accepted input beat
	typedef struct packed {
		logic        valid;
		logic [2:0]  opcode;
		logic [5:0]  row;
		logic [5:0]  col;
		logic [2:0]  kernel;
		logic        which;
		logic [31:0] value;
	} host_cmd_t;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] res;
		if (x > 64'sh0000_0000_7FFF_FFFF) res = 32'sh7FFF_FFFF;
		else if (x < -64'sh0000_0000_8000_0000) res = -32'sh8000_0000;
		else res = x[31:0];
		return res;
	endfunction

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] res;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) res = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else res = s[63:0];
		return res;
	endfunction

endpackage

[rtl/wksa_ram.sv]
// Simple dual-port synchronous RAM, registered read data
module wksa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) rdata <= mem[raddr];
	end
endmodule

[rtl/wksa_core.sv]
// Stores and compute sequencer: clear, vector forming and read-modify-write accumulation
module wksa_core (
	input  logic                clk,
	input  logic                arst_n,
	input  wksa_pkg::host_cmd_t cmd,
	input  wksa_pkg::cfg_t      cfg,
	output logic                idle,
	output logic [63:0]         rd_value
);
	import wksa_pkg::*;

	typedef enum logic [17:0] {
		S_IDLE = 18'h00001,
		S_CLR  = 18'h00002,
		S_ROW  = 18'h00004,
		S_PJ   = 18'h00008,
		S_PW   = 18'h00010,
		S_DW   = 18'h00020,
		S_VR   = 18'h00040,
		S_VC   = 18'h00080,
		S_VKJ  = 18'h00100,
		S_VD   = 18'h00200,
		S_VMUL = 18'h00400,
		S_VSUM = 18'h00800,
		S_AR   = 18'h01000,
		S_ARD  = 18'h02000,
		S_AL   = 18'h04000,
		S_AP   = 18'h08000,
		S_AQ   = 18'h10000,
		S_AW   = 18'h20000
	} state_t;

	state_t             state_q;
	logic               comp_q;
	logic [SQ_AW-1:0]   clr_q;
	logic [IDX_W:0]     i_q, j_q, r_q, l_q;
	logic [KER_W:0]     c_q;
	logic               diag_q;
	logic               rd_which_q;

	logic signed [31:0] w_q, ki_q, tvr_q;
	logic signed [32:0] d_q;
	logic signed [64:0] prod_q;
	logic signed [52:0] acc_q;
	logic signed [63:0] p_q, term_q;

	logic [IDX_W:0]     n_eff, stop_eff;
	logic [KER_W:0]     m_eff;

	logic               k_re, bw_re, pw_re, dw_re, tv_re, tv_we, sc_re;
	logic [KS_AW-1:0]   k_raddr;
	logic [IDX_W-1:0]   tv_raddr;
	logic [SQ_AW-1:0]   sc_raddr, sc_waddr;
	logic [31:0]        k_rdata, bw_rdata, pw_rdata, dw_rdata, tv_rdata;
	logic [63:0]        sp_rdata, sd_rdata, sc_wdata;
	logic               sp_we, sd_we;
	logic               host_ld;
	logic signed [63:0] acc_term, acc_old;

	assign n_eff    = (cfg.active_size > 7'(MAX_SIZE)) ? 7'(MAX_SIZE) : cfg.active_size;
	assign m_eff    = (cfg.kernels_in_use > 4'(MAX_KERNELS)) ? 4'(MAX_KERNELS)
		: cfg.kernels_in_use;
	assign stop_eff = (cfg.end_row > n_eff) ? n_eff : cfg.end_row;

	assign idle    = (state_q == S_IDLE);
	assign host_ld = cmd.valid && idle;

	// memory controls
	assign k_re     = (state_q == S_VC) || (state_q == S_VKJ);
	assign k_raddr  = (state_q == S_VC)
		? {c_q[KER_W-1:0], i_q[IDX_W-1:0], r_q[IDX_W-1:0]}
		: {c_q[KER_W-1:0], j_q[IDX_W-1:0], r_q[IDX_W-1:0]};
	assign bw_re    = (state_q == S_VC);
	assign pw_re    = (state_q == S_PJ) && (j_q < n_eff);
	assign dw_re    = (state_q == S_PJ) && !(j_q < n_eff);
	assign tv_we    = (state_q == S_VC) && !(c_q < m_eff);
	assign tv_re    = (state_q == S_AR) || (state_q == S_AL);
	assign tv_raddr = (state_q == S_AR) ? r_q[IDX_W-1:0] : l_q[IDX_W-1:0];
	assign sc_re    = (host_ld && cmd.opcode == OP_READ) || (state_q == S_AL);
	assign sc_raddr = idle ? {cmd.row, cmd.col} : {r_q[IDX_W-1:0], l_q[IDX_W-1:0]};

	assign acc_term = diag_q ? (term_q >>> 16) : (term_q >>> 15);
	assign acc_old  = diag_q ? $signed(sd_rdata) : $signed(sp_rdata);
	assign sc_waddr = (state_q == S_CLR) ? clr_q : {r_q[IDX_W-1:0], l_q[IDX_W-1:0]};
	assign sc_wdata = (state_q == S_CLR) ? 64'd0 : sat_add64(acc_old, acc_term);
	assign sp_we    = (state_q == S_CLR) || ((state_q == S_AW) && !diag_q);
	assign sd_we    = (state_q == S_CLR) || ((state_q == S_AW) && diag_q);

	assign rd_value = rd_which_q ? sd_rdata : sp_rdata;

	wksa_ram #(.WIDTH(32), .DEPTH(MAX_KERNELS * MAX_SIZE * MAX_SIZE)) u_kstore (
		.clk(clk), .we(host_ld && cmd.opcode == OP_KERNEL),
		.waddr({cmd.kernel, cmd.row, cmd.col}), .wdata(cmd.value),
		.re(k_re), .raddr(k_raddr), .rdata(k_rdata));

	wksa_ram #(.WIDTH(32), .DEPTH(MAX_KERNELS)) u_kweight (
		.clk(clk), .we(host_ld && cmd.opcode == OP_KWEIGHT),
		.waddr(cmd.kernel), .wdata(cmd.value),
		.re(bw_re), .raddr(c_q[KER_W-1:0]), .rdata(bw_rdata));

	wksa_ram #(.WIDTH(32), .DEPTH(MAX_SIZE * MAX_SIZE)) u_pweight (
		.clk(clk), .we(host_ld && cmd.opcode == OP_PWEIGHT),
		.waddr({cmd.row, cmd.col}), .wdata(cmd.value),
		.re(pw_re), .raddr({i_q[IDX_W-1:0], j_q[IDX_W-1:0]}), .rdata(pw_rdata));

	wksa_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_dweight (
		.clk(clk), .we(host_ld && cmd.opcode == OP_DWEIGHT),
		.waddr(cmd.row), .wdata(cmd.value),
		.re(dw_re), .raddr(i_q[IDX_W-1:0]), .rdata(dw_rdata));

	wksa_ram #(.WIDTH(32), .DEPTH(MAX_SIZE)) u_tvec (
		.clk(clk), .we(tv_we), .waddr(r_q[IDX_W-1:0]),
		.wdata(sat32(64'(acc_q))),
		.re(tv_re), .raddr(tv_raddr), .rdata(tv_rdata));

	wksa_ram #(.WIDTH(64), .DEPTH(MAX_SIZE * MAX_SIZE)) u_pscatter (
		.clk(clk), .we(sp_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.re(sc_re), .raddr(sc_raddr), .rdata(sp_rdata));

	wksa_ram #(.WIDTH(64), .DEPTH(MAX_SIZE * MAX_SIZE)) u_dscatter (
		.clk(clk), .we(sd_we), .waddr(sc_waddr), .wdata(sc_wdata),
		.re(sc_re), .raddr(sc_raddr), .rdata(sd_rdata));

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLR;
			comp_q     <= 1'b0;
			clr_q      <= '0;
			i_q        <= '0;
			j_q        <= '0;
			r_q        <= '0;
			l_q        <= '0;
			c_q        <= '0;
			diag_q     <= 1'b0;
			rd_which_q <= 1'b0;
		end else begin
			if (host_ld && cmd.opcode == OP_READ) rd_which_q <= cmd.which;
			unique case (state_q)
				S_IDLE: begin
					if (host_ld && cmd.opcode == OP_COMPUTE) begin
						comp_q  <= 1'b1;
						clr_q   <= '0;
						i_q     <= cfg.start_row;
						state_q <= S_CLR;
					end
				end
				S_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) state_q <= comp_q ? S_ROW : S_IDLE;
				end
				S_ROW: begin
					if (i_q < stop_eff) begin
						j_q     <= i_q + 1'b1;
						state_q <= S_PJ;
					end else begin
						comp_q  <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_PJ: begin
					if (j_q < n_eff) state_q <= S_PW;
					else begin
						diag_q  <= 1'b1;
						state_q <= S_DW;
					end
				end
				S_PW: begin
					if (pw_rdata != 32'd0) begin
						diag_q  <= 1'b0;
						r_q     <= '0;
						state_q <= S_VR;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_PJ;
					end
				end
				S_DW: begin
					r_q     <= '0;
					state_q <= S_VR;
				end
				S_VR: begin
					if (r_q < n_eff) begin
						c_q     <= '0;
						state_q <= S_VC;
					end else begin
						r_q     <= '0;
						state_q <= S_AR;
					end
				end
				S_VC: begin
					if (c_q < m_eff) state_q <= S_VKJ;
					else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_VR;
					end
				end
				S_VKJ:  state_q <= S_VD;
				S_VD:   state_q <= S_VMUL;
				S_VMUL: state_q <= S_VSUM;
				S_VSUM: begin
					c_q     <= c_q + 1'b1;
					state_q <= S_VC;
				end
				S_AR: begin
					if (r_q < n_eff) state_q <= S_ARD;
					else if (diag_q) begin
						i_q     <= i_q + 1'b1;
						state_q <= S_ROW;
					end else begin
						j_q     <= j_q + 1'b1;
						state_q <= S_PJ;
					end
				end
				S_ARD: begin
					l_q     <= r_q;
					state_q <= S_AL;
				end
				S_AL: begin
					if (l_q < n_eff) state_q <= S_AP;
					else begin
						r_q     <= r_q + 1'b1;
						state_q <= S_AR;
					end
				end
				S_AP: state_q <= S_AQ;
				S_AQ: state_q <= S_AW;
				S_AW: begin
					l_q     <= l_q + 1'b1;
					state_q <= S_AL;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// arithmetic datapath
	always_ff @(posedge clk) begin
		if (state_q == S_PW) w_q <= $signed(pw_rdata);
		if (state_q == S_DW) w_q <= $signed(dw_rdata);
		if (state_q == S_VR) acc_q <= '0;
		if (state_q == S_VKJ) ki_q <= $signed(k_rdata);
		if (state_q == S_VD)
			d_q <= diag_q ? 33'(ki_q) : 33'(ki_q) - 33'($signed(k_rdata));
		if (state_q == S_VMUL) prod_q <= d_q * $signed(bw_rdata);
		if (state_q == S_VSUM) acc_q <= acc_q + 53'(prod_q >>> 16);
		if (state_q == S_ARD) tvr_q <= $signed(tv_rdata);
		if (state_q == S_AP) p_q <= tvr_q * $signed(tv_rdata);
		if (state_q == S_AQ) term_q <= w_q * sat32(p_q >>> 16);
	end
endmodule

[rtl/weighted_kernel_scatter_accumulate_unit.sv]
// Weighted kernel scatter accumulate unit.
// Input channel (in_valid/in_ready) takes one command beat: loads of kernel
// elements, kernel weights, pair weights and diagonal weights, a compute
// command, or a read of one Q48.16 entry of the pair or diagonal scatter.
// Loads are accepted back to back.
// A read presents its beat on the output channel (out_valid/out_ready) from the
// output register, loaded from the registered scatter read data while pend_q is set;
// the next read waits until the output register is free. Compute first clears
// all 4096 entries of both scatter memories, then walks rows start_row to
// min(end_row, N)-1; per formed vector it reads the kernel store, then does the
// read-modify-write of the scatter memory, one entry at a time. in_ready is
// low for the whole compute.
// Reset runs the same clearing pass with in_ready low;
// configuration writes are taken at any time.
// A stalled receiver holds the read beat in the output register while loads
// continue to be accepted.
module weighted_kernel_scatter_accumulate_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [2:0]         opcode,
	input  logic [5:0]         row,
	input  logic [5:0]         col,
	input  logic [2:0]         kernel,
	input  logic               which_matrix,
	input  logic signed [31:0] load_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [63:0] entry_value,
	output logic               entry_matrix,
	output logic [5:0]         entry_row,
	output logic [5:0]         entry_col,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [6:0]         cfg_data
);
	import wksa_pkg::*;

	cfg_t        cfg_q;
	host_cmd_t   cmd;
	logic        core_idle;
	logic [63:0] rd_value;
	logic        pend_q;
	logic        out_valid_q;
	logic [63:0] value_q;
	logic        matrix_q, matrix_s1;
	logic [5:0]  row_q, col_q, row_s1, col_s1;
	logic        accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.active_size    <= 7'(MAX_SIZE);
			cfg_q.kernels_in_use <= 4'(MAX_KERNELS);
			cfg_q.start_row      <= 7'd0;
			cfg_q.end_row        <= 7'(MAX_SIZE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ACTIVE_SIZE: cfg_q.active_size    <= cfg_data;
				CFG_KERNELS:     cfg_q.kernels_in_use <= cfg_data[3:0];
				CFG_START_ROW:   cfg_q.start_row      <= cfg_data;
				CFG_END_ROW:     cfg_q.end_row        <= cfg_data;
				default: ;
			endcase
		end
	end

	// a read needs the output register free by the time its data lands
	assign in_ready = core_idle && !(opcode == OP_READ && (pend_q || (out_valid_q && !out_ready)));
	assign accept   = in_valid && in_ready;

	assign cmd.valid  = accept;
	assign cmd.opcode = opcode;
	assign cmd.row    = row;
	assign cmd.col    = col;
	assign cmd.kernel = kernel;
	assign cmd.which  = which_matrix;
	assign cmd.value  = load_value;

	wksa_core u_core (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .cfg(cfg_q),
		.idle(core_idle), .rd_value(rd_value));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			pend_q <= accept && opcode == OP_READ;
			if (pend_q) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && opcode == OP_READ) begin
			matrix_s1 <= which_matrix;
			row_s1    <= row;
			col_s1    <= col;
		end
		if (pend_q) begin
			value_q  <= rd_value;
			matrix_q <= matrix_s1;
			row_q    <= row_s1;
			col_q    <= col_s1;
		end
	end

	assign out_valid    = out_valid_q;
	assign entry_value  = $signed(value_q);
	assign entry_matrix = matrix_q;
	assign entry_row    = row_q;
	assign entry_col    = col_q;

`include "weighted_kernel_scatter_accumulate_unit_assert.svh"

	`WKSA_ASSERT_SAME(a_pend_slot_free, pend_q, !out_valid_q, "read data lands on a full output register")
	`WKSA_ASSERT_NEXT(a_pend_delivers, pend_q, out_valid_q, "pending read beat not presented")
	`WKSA_ASSERT_NEXT(a_compute_busy, accept && opcode == OP_COMPUTE, !in_ready, "input taken during compute")
endmodule
